/* rtl/lfi_pkg.sv */
// Shared types, constants and the microcode program of the light flicker intensity unit.
// Depends on nothing; every other rtl file imports it.
package lfi_pkg;

  // defaults for the top-level parameters
  localparam int MAX_SLOTS_DEF  = 16;
  localparam int SINE_DEPTH_DEF = 256;

  // field and datapath widths
  localparam int SLOT_W  = 8;
  localparam int INT_W   = 15;
  localparam int TIME_W  = 32;
  localparam int SEED_W  = 16;
  localparam int ANG_W   = 16;
  localparam int SINE_W  = 18;   // signed Q.16, +-1.0 at the peaks
  localparam int FREQ_W  = 19;
  localparam int MUL_W   = 32;
  localparam int PROD_W  = 64;
  localparam int G_W     = 33;   // turn rate, Q.32 turns/s
  localparam int WGT_W   = 17;
  localparam int WPROD_W = 35;
  localparam int ACC_W   = 36;

  localparam logic [SEED_W-1:0] SEED_STEP      = 16'd3854;
  localparam logic [MUL_W-1:0]  INV_TWO_PI_Q32 = 32'd683565276;

  localparam int TERMS  = 3;
  localparam int TERM_W = 2;
  localparam logic [TERM_W-1:0] LAST_TERM = 2'd2;

  localparam logic [FREQ_W-1:0] FREQ_BASE [TERMS] = '{19'd72090, 19'd176947, 19'd294912};
  localparam logic [17:0]       FREQ_GAIN [TERMS] = '{18'd58982, 18'd85197, 18'd137626};
  localparam logic [17:0]       PHASE_MUL [TERMS] = '{18'd65536, 18'd111411, 18'd150733};
  localparam logic signed [WGT_W-1:0] WEIGHT [TERMS] = '{17'sd52429, 17'sd19661, 17'sd6554};

  localparam logic signed [ACC_W-1:0] BASE_Q32   = 36'sd12884901888;
  localparam logic signed [ACC_W-1:0] LIM_LO     = 36'sd6442450944;
  localparam logic signed [ACC_W-1:0] LIM_HI     = 36'sd19327352832;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = 36'sd524288;

  localparam logic [INT_W-1:0] SLOT0_INTENSITY = 15'd14336;
  localparam logic [INT_W-1:0] INT_MIN_Q12     = 15'd6144;
  localparam logic [INT_W-1:0] INT_MAX_Q12     = 15'd18432;

  // micro-operations of the datapath
  typedef enum logic [3:0] {
    OP_NOP,
    OP_MUL_GAIN,
    OP_MUL_FREQ,
    OP_MUL_PHASE,
    OP_MUL_TIME,
    OP_ANGLE,
    OP_SINE,
    OP_WEIGHT,
    OP_ACCUM,
    OP_FINISH
  } lfi_op_t;

  typedef enum logic [1:0] {
    JMP_NEXT,   // fall through
    JMP_LOOP,   // back to target while terms remain
    JMP_HOLD    // stay until the output register has room, then retire
  } lfi_jmp_t;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] lfi_pc_t;

  localparam lfi_pc_t PC_TERM   = 4'd0;
  localparam lfi_pc_t PC_FINISH = 4'd8;

  typedef struct packed {
    lfi_op_t  op;
    lfi_jmp_t jmp;
    lfi_pc_t  target;
  } lfi_uword_t;

  typedef struct packed {
    lfi_op_t           op;
    logic [TERM_W-1:0] term;
  } lfi_ctrl_t;

  // control store: one sine term per pass of steps 0..7
  function automatic lfi_uword_t ucode(lfi_pc_t pc);
    lfi_uword_t w;
    unique case (pc)
      4'd0:    w = '{OP_MUL_GAIN,  JMP_NEXT, PC_TERM};
      4'd1:    w = '{OP_MUL_FREQ,  JMP_NEXT, PC_TERM};
      4'd2:    w = '{OP_MUL_PHASE, JMP_NEXT, PC_TERM};
      4'd3:    w = '{OP_MUL_TIME,  JMP_NEXT, PC_TERM};
      4'd4:    w = '{OP_ANGLE,     JMP_NEXT, PC_TERM};
      4'd5:    w = '{OP_SINE,      JMP_NEXT, PC_TERM};
      4'd6:    w = '{OP_WEIGHT,    JMP_NEXT, PC_TERM};
      4'd7:    w = '{OP_ACCUM,     JMP_LOOP, PC_TERM};
      default: w = '{OP_FINISH,    JMP_HOLD, PC_FINISH};
    endcase
    return w;
  endfunction

  // sin(pi/2 * x), x in Q0.16 over 0..65536, result Q.16 (elaboration only)
  function automatic longint unsigned quarter_sine(longint unsigned x);
    longint unsigned x2;
    longint unsigned t;
    x2 = (x * x) >> 16;
    t  = (64'd4640 * x2) >> 16;
    t  = 64'd42048 - t;
    t  = (t * x2) >> 16;
    t  = 64'd102944 - t;
    return (t * x) >> 16;
  endfunction

  // sine of u turns, u in Q0.16
  function automatic logic signed [SINE_W-1:0] sine_of_turn(longint unsigned u);
    longint unsigned q;
    longint unsigned x;
    longint unsigned m;
    q = (u >> 14) & 64'd3;
    x = (u & 64'h3FFF) << 2;
    m = q[0] ? quarter_sine(64'd65536 - x) : quarter_sine(x);
    return q[1] ? -SINE_W'(m) : SINE_W'(m);
  endfunction

endpackage

/* rtl/lfi_sine_rom.sv */
// Sine lookup ROM, one turn over DEPTH entries, registered read.
// Depends on lfi_pkg (sine_of_turn, SINE_W).
module lfi_sine_rom import lfi_pkg::*; #(
  parameter int DEPTH = SINE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  output logic signed [SINE_W-1:0] data
);

  logic signed [SINE_W-1:0] rom [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_entry
    localparam longint unsigned TURN = (longint'(k) * 65536) / DEPTH;
    assign rom[k] = sine_of_turn(TURN);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= rom[addr];
    end
  end

endmodule

/* rtl/lfi_seq.sv */
// Microcode sequencer: program counter, term counter and jump logic over the control store.
// Depends on lfi_pkg (ucode, lfi_ctrl_t).
module lfi_seq import lfi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      flick,
  input  logic      out_room,
  output logic      busy,
  output lfi_ctrl_t ctrl
);

  lfi_pc_t           pc;
  logic [TERM_W-1:0] term;
  lfi_uword_t        uw;

  assign uw        = ucode(pc);
  assign ctrl.op   = busy ? uw.op : OP_NOP;
  assign ctrl.term = term;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= PC_TERM;
      term <= '0;
    end else if (!busy) begin
      if (start) begin
        busy <= 1'b1;
        pc   <= flick ? PC_TERM : PC_FINISH;
        term <= '0;
      end
    end else begin
      unique case (uw.jmp)
        JMP_NEXT: pc <= pc + lfi_pc_t'(1);
        JMP_LOOP: begin
          if (term != LAST_TERM) begin
            term <= term + TERM_W'(1);
            pc   <= uw.target;
          end else begin
            pc <= pc + lfi_pc_t'(1);
          end
        end
        JMP_HOLD: begin
          if (out_room) begin
            busy <= 1'b0;
          end
        end
        default: pc <= PC_FINISH;
      endcase
    end
  end

endmodule

/* rtl/lfi_dp.sv */
// Datapath: light count, shared 32x32 multiplier, sine ROM, weighted accumulator, result register.
// Depends on lfi_pkg and lfi_sine_rom.
module lfi_dp import lfi_pkg::*; #(
  parameter int MAX_SLOTS        = MAX_SLOTS_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              kind,
  input  logic [TIME_W-1:0] time_req,
  input  lfi_ctrl_t         ctrl,
  input  logic              out_ready,
  output logic              flick,
  output logic              out_room,
  output logic              out_valid,
  output logic              accepted,
  output logic [SLOT_W-1:0] slot,
  output logic [INT_W-1:0]  intensity
);

  localparam int COUNT_W = $clog2(MAX_SLOTS + 1);
  localparam int ADDR_W  = $clog2(SINE_TABLE_DEPTH);
  localparam int IDX_W   = ANG_W + 13;

  logic [COUNT_W-1:0]       count;
  logic                     full;
  logic [TIME_W-1:0]        time_r;
  logic [SEED_W-1:0]        seed;
  logic                     res_add;
  logic                     res_fixed;
  logic [SLOT_W-1:0]        res_slot;
  logic [PROD_W-1:0]        prod;
  logic [G_W-1:0]           g;
  logic [ANG_W-1:0]         ph;
  logic [ANG_W-1:0]         ang;
  logic signed [WPROD_W-1:0] wprod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SINE_W-1:0] sine;
  logic [MUL_W-1:0]         mul_a;
  logic [MUL_W-1:0]         mul_b;
  logic [PROD_W-1:0]        mul_out;
  logic [FREQ_W-1:0]        freq;
  logic [IDX_W-1:0]         idx_full;
  logic signed [ACC_W-1:0]  clamped;
  logic signed [ACC_W-1:0]  rounded;
  logic                     fin;

  assign full     = count >= COUNT_W'(MAX_SLOTS);
  assign flick    = kind && !full && (count != '0);
  assign out_room = !out_valid || out_ready;
  assign fin      = (ctrl.op == OP_FINISH) && out_room;

  assign freq = FREQ_BASE[ctrl.term] + FREQ_W'(prod[33:16]);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.op)
      OP_MUL_GAIN: begin
        mul_a = MUL_W'(FREQ_GAIN[ctrl.term]);
        mul_b = MUL_W'(seed);
      end
      OP_MUL_FREQ: begin
        mul_a = MUL_W'(freq);
        mul_b = INV_TWO_PI_Q32;
      end
      OP_MUL_PHASE: begin
        mul_a = MUL_W'(seed);
        mul_b = MUL_W'(PHASE_MUL[ctrl.term]);
      end
      OP_MUL_TIME: begin
        mul_a = time_r;
        mul_b = g[MUL_W-1:0];
      end
      default: ;
    endcase
  end

  assign mul_out = PROD_W'(mul_a) * PROD_W'(mul_b);

  // table index = floor(angle * depth / 2^16)
  assign idx_full = IDX_W'(ang) * IDX_W'(SINE_TABLE_DEPTH);

  lfi_sine_rom #(
    .DEPTH(SINE_TABLE_DEPTH)
  ) u_rom (
    .clk (clk),
    .en  (ctrl.op == OP_SINE),
    .addr(idx_full[ANG_W +: ADDR_W]),
    .data(sine)
  );

  always_comb begin
    clamped = acc;
    if (acc < LIM_LO) begin
      clamped = LIM_LO;
    end else if (acc > LIM_HI) begin
      clamped = LIM_HI;
    end
  end

  assign rounded = clamped + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (start) begin
        if (!kind) begin
          count <= '0;
        end else if (!full) begin
          count <= count + COUNT_W'(1);
        end
      end
      if (fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      time_r    <= time_req;
      seed      <= SEED_W'(32'(count) * 32'(SEED_STEP));
      res_add   <= kind && !full;
      res_fixed <= (count == '0);
      res_slot  <= SLOT_W'(count);
      acc       <= BASE_Q32;
    end else begin
      case (ctrl.op) inside
        OP_MUL_GAIN, OP_MUL_FREQ: prod <= mul_out;
        OP_MUL_PHASE: begin
          prod <= mul_out;
          g    <= prod[48:16];
        end
        OP_MUL_TIME: begin
          prod <= mul_out;
          ph   <= prod[31:16];
        end
        // bits 47:32 of time * rate, the rate's bit 32 folded in as a shifted add
        OP_ANGLE:  ang   <= prod[47:32] + (g[G_W-1] ? time_r[ANG_W-1:0] : '0) + ph;
        OP_WEIGHT: wprod <= WPROD_W'(WEIGHT[ctrl.term]) * WPROD_W'(sine);
        OP_ACCUM:  acc   <= acc + ACC_W'(wprod);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      accepted  <= res_add;
      slot      <= res_add ? res_slot : '0;
      intensity <= !res_add  ? '0 :
                   res_fixed ? SLOT0_INTENSITY : rounded[34:20];
    end
  end

endmodule

/* rtl/light_flicker_intensity_unit.sv */
// Top level of the light flicker intensity unit: sequencer plus datapath.
// Depends on lfi_pkg, lfi_seq, lfi_dp (and through it lfi_sine_rom).
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------
//  in      | input     | in_valid / in_ready | kind, time_req
//  out     | output    | out_valid/out_ready | accepted, slot, intensity
//
// Sequencing: an add that needs the flicker sum runs 3 passes of an 8-step
// microprogram plus a finish step; the result and in_ready come together as
// the finish step retires. The single shared 32x32 multiplier sets the
// step count.
// Clears, rejected adds and slot 0 go straight to the finish step.
// Reset (rst, synchronous) empties the light table and the output register.
// A stalled out channel holds the sequencer on its finish step; the next
// in beat is taken as soon as the finished result sits in the output register.
module light_flicker_intensity_unit import lfi_pkg::*; #(
  parameter int MAX_SLOTS        = MAX_SLOTS_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              kind,
  input  logic [TIME_W-1:0] time_req,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              accepted,
  output logic [SLOT_W-1:0] slot,
  output logic [INT_W-1:0]  intensity
);

  logic      busy;
  logic      start;
  logic      flick;
  logic      out_room;
  lfi_ctrl_t ctrl;

  // one item in flight; the output register decouples the out side
  assign in_ready = !busy;
  assign start    = in_valid && in_ready;

  lfi_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .flick   (flick),
    .out_room(out_room),
    .busy    (busy),
    .ctrl    (ctrl)
  );

  lfi_dp #(
    .MAX_SLOTS       (MAX_SLOTS),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .kind     (kind),
    .time_req (time_req),
    .ctrl     (ctrl),
    .out_ready(out_ready),
    .flick    (flick),
    .out_room (out_room),
    .out_valid(out_valid),
    .accepted (accepted),
    .slot     (slot),
    .intensity(intensity)
  );

  // a taken beat always leaves in_ready low in the cycle after it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready stayed high after an accepted beat");

  // rejected and clear results carry no slot or intensity
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !accepted) |-> (slot == '0 && intensity == '0))
    else $error("non-accepted result with nonzero payload");

  // clamp holds the flicker sum to 1.5..4.5
  a_intensity_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && accepted) |-> (intensity >= INT_MIN_Q12 && intensity <= INT_MAX_Q12))
    else $error("intensity outside clamp range");

  // a result only appears as the sequencer retires an item
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(busy))
    else $error("result appeared without an item in flight");

endmodule
